FILE: design/omm_pkg.sv
// Package for the one-mismatch pattern matcher.
// Holds the shared widths, limits, function codes and cell types; no dependencies.
package omm_pkg;

  localparam int unsigned MaxPattern = 64;
  localparam int unsigned PatIdxW    = 6;
  localparam int unsigned SymW       = 8;
  localparam int unsigned LenW       = 7;
  localparam int unsigned PosW       = 21;
  localparam int unsigned CntW       = 2;

  localparam logic [PosW-1:0] MaxText    = PosW'(1 << 20);
  localparam logic [LenW-1:0] MaxLen     = LenW'(MaxPattern);
  localparam logic [CntW-1:0] CntSat     = CntW'(2);
  localparam logic [LenW-1:0] LenReset   = LenW'(1);

  typedef enum logic [1:0] {
    FuncLoad  = 2'd0,
    FuncText  = 2'd1,
    FuncStart = 2'd2
  } func_e;

  typedef struct packed {
    logic            vld;
    logic [CntW-1:0] cnt;
  } cell_state_t;

  typedef struct packed {
    logic            shift;
    logic            clear;
    logic [SymW-1:0] sym;
  } cell_ctrl_t;

endpackage

FILE: design/omm_cell.sv
// One comparator cell of the matcher chain: one pattern byte and one window count.
// Depends on omm_pkg.
module omm_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  omm_pkg::cell_ctrl_t  ctrl_i,
  input  logic                 load_i,
  input  logic                 active_i,
  input  omm_pkg::cell_state_t prev_i,
  output omm_pkg::cell_state_t state_d_o,
  output omm_pkg::cell_state_t state_q_o
);

  logic [omm_pkg::SymW-1:0] pat_q;
  omm_pkg::cell_state_t     state_d;
  omm_pkg::cell_state_t     state_q;
  logic                     mism;

  always_comb begin
    mism        = (ctrl_i.sym != pat_q);
    state_d.vld = prev_i.vld;
    state_d.cnt = prev_i.cnt;
    if (active_i && mism && (prev_i.cnt < omm_pkg::CntSat)) begin
      state_d.cnt = prev_i.cnt + omm_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= ctrl_i.sym;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (ctrl_i.clear) begin
      state_q <= '0;
    end else if (ctrl_i.shift) begin
      state_q <= state_d;
    end
  end

  assign state_d_o = state_d;
  assign state_q_o = state_q;

endmodule

FILE: design/omm_out_buf.sv
// Two-entry output buffer (output register plus skid entry) for matcher results.
// Depends on omm_pkg.
module omm_out_buf (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     res_valid_i,
  input  logic [omm_pkg::PosW-1:0] res_pos_i,
  input  logic                     res_mis_i,
  output logic                     full_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [omm_pkg::PosW-1:0] out_pos_o,
  output logic                     out_mis_o
);

  logic                     out_valid_q;
  logic [omm_pkg::PosW-1:0] out_pos_q;
  logic                     out_mis_q;
  logic                     skid_valid_q;
  logic [omm_pkg::PosW-1:0] skid_pos_q;
  logic                     skid_mis_q;
  logic                     free;

  assign free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (free) begin
      out_valid_q  <= skid_valid_q || res_valid_i;
      skid_valid_q <= 1'b0;
    end else if (res_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      out_pos_q <= skid_valid_q ? skid_pos_q : res_pos_i;
      out_mis_q <= skid_valid_q ? skid_mis_q : res_mis_i;
    end else if (res_valid_i) begin
      skid_pos_q <= res_pos_i;
      skid_mis_q <= res_mis_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_pos_o   = out_pos_q;
  assign out_mis_o   = out_mis_q;

endmodule

FILE: design/one_mismatch_pattern_matcher.sv
// Top level of the one-mismatch pattern matcher: a chain of comparator cells and
// an output buffer. Depends on omm_pkg, omm_cell and omm_out_buf.
//
// The block takes one item per cycle while not stalled, pattern loads and text bytes
// alike, set by a chain of 64 comparator cells, one per pattern position, that all
// update in the same cycle as a text byte is accepted. Each cell holds one pattern
// byte and the saturating mismatch count of the window that compares against it
// next; the counts move one cell along with every text byte. A hitting window is
// registered in the output buffer on its last byte, with its 1-based start and its
// mismatch count. A two-entry output buffer lets input continue while a result
// waits; input stalls only when both entries are held. Write pattern_length and
// pattern bytes before a text, then send a start item to begin it.
module one_mismatch_pattern_matcher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [omm_pkg::LenW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [omm_pkg::SymW-1:0]    symbol_i,
  input  logic [omm_pkg::PatIdxW-1:0] pattern_index_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [omm_pkg::PosW-1:0]    start_position_o,
  output logic                        mismatch_count_o
);

  logic [omm_pkg::LenW-1:0]    len_q;
  logic [omm_pkg::LenW-1:0]    len_eff;
  logic [omm_pkg::PatIdxW-1:0] tail;
  logic [omm_pkg::PosW-1:0]    text_count_q;
  logic                        buf_full;
  logic                        in_acc;
  logic                        load_acc;
  logic                        text_acc;
  logic                        start_acc;
  logic                        res_valid;
  logic [omm_pkg::PosW-1:0]    res_pos;
  omm_pkg::cell_ctrl_t         ctrl;
  omm_pkg::cell_state_t        cell_q [omm_pkg::MaxPattern];
  omm_pkg::cell_state_t        cell_d [omm_pkg::MaxPattern];
  omm_pkg::cell_state_t        tail_d;

  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i && !buf_full;

  always_comb begin
    load_acc  = 1'b0;
    text_acc  = 1'b0;
    start_acc = 1'b0;
    case (omm_pkg::func_e'(func_i))
      omm_pkg::FuncLoad:  load_acc  = in_acc;
      omm_pkg::FuncText:  text_acc  = in_acc && (text_count_q < omm_pkg::MaxText);
      omm_pkg::FuncStart: start_acc = in_acc;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= omm_pkg::LenReset;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_count_q <= '0;
    end else if (start_acc) begin
      text_count_q <= '0;
    end else if (text_acc) begin
      text_count_q <= text_count_q + omm_pkg::PosW'(1);
    end
  end

  assign len_eff    = (len_q > omm_pkg::MaxLen) ? omm_pkg::MaxLen : len_q;
  assign tail       = omm_pkg::PatIdxW'(len_eff - omm_pkg::LenW'(1));
  assign ctrl.shift = text_acc;
  assign ctrl.clear = start_acc;
  assign ctrl.sym   = symbol_i;

  for (genvar j = 0; j < omm_pkg::MaxPattern; j++) begin : g_cell
    omm_pkg::cell_state_t prev;
    logic                 load;
    logic                 active;

    if (j == 0) begin : g_head
      assign prev.vld = 1'b1;
      assign prev.cnt = '0;
    end else begin : g_link
      assign prev = cell_q[j-1];
    end

    assign load   = load_acc && (pattern_index_i == omm_pkg::PatIdxW'(j));
    assign active = (omm_pkg::LenW'(j) < len_eff);

    omm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .load_i    (load),
      .active_i  (active),
      .prev_i    (prev),
      .state_d_o (cell_d[j]),
      .state_q_o (cell_q[j])
    );
  end

  assign tail_d    = cell_d[tail];
  assign res_valid = text_acc && (len_eff != '0) && tail_d.vld &&
                     (tail_d.cnt < omm_pkg::CntSat);
  assign res_pos   = text_count_q - omm_pkg::PosW'(len_eff) + omm_pkg::PosW'(2);

  omm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_pos_i   (res_pos),
    .res_mis_i   (tail_d.cnt[0]),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pos_o   (start_position_o),
    .out_mis_o   (mismatch_count_o)
  );

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_full |-> out_valid_o)
    else $error("skid entry held while output register is empty");

  a_text_fills_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_acc |=> cell_q[0].vld)
    else $error("head cell not valid after a text item");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_acc |=> (text_count_q == '0) && !cell_q[0].vld)
    else $error("start item did not clear the text state");

  a_hit_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (res_pos != '0))
    else $error("hit reported with a zero start position");
`endif

endmodule
